>>> sv/sie_pkg.sv
// Shared types and constants of the Simpson integrator with end correction.
`default_nettype none

package sie_pkg;

   localparam int CFG_W    = 10;
   localparam int STEP_W   = 32;
   localparam int SAMPLE_W = 32;
   localparam int RESULT_W = 64;
   localparam int ACC_W    = 48;
   localparam int WEIGHT_W = 7;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_RANGE,
      STATUS_COUNT
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_SIZE,
      REG_GRID_FIRST,
      REG_GRID_LAST,
      REG_RANGE_START,
      REG_RANGE_END
   } csr_index_type;

   // Weights are 8x Simpson weights and 24x end-rule weights
   localparam logic signed [WEIGHT_W-1:0] W_SIMP_END  = 7'sd8;
   localparam logic signed [WEIGHT_W-1:0] W_SIMP_ODD  = 7'sd32;
   localparam logic signed [WEIGHT_W-1:0] W_SIMP_EVEN = 7'sd16;
   localparam logic signed [WEIGHT_W-1:0] W_TRAP      = 7'sd12;
   localparam logic signed [WEIGHT_W-1:0] W_CUBIC_IN  = 7'sd13;
   localparam logic signed [WEIGHT_W-1:0] W_CUBIC_OUT = -7'sd1;
   localparam logic signed [WEIGHT_W-1:0] W_QUAD_NEAR = 7'sd16;
   localparam logic signed [WEIGHT_W-1:0] W_QUAD_FAR  = 7'sd10;
   localparam logic signed [WEIGHT_W-1:0] W_QUAD_OUT  = -7'sd2;

   typedef struct packed {
      logic [STEP_W-1:0] step_size;
      logic [CFG_W-1:0]  grid_first;
      logic [CFG_W-1:0]  grid_last;
      logic [CFG_W-1:0]  range_start;
      logic [CFG_W-1:0]  range_end;
   } cfg_type;

   typedef struct packed {
      logic go;
      logic bad_range;
      logic count_bad;
   } start_type;

   typedef struct packed {
      logic                       valid;
      logic signed [WEIGHT_W-1:0] weight;
   } term_type;

endpackage

`default_nettype wire

>>> sv/sie_if.sv
// Channel interfaces: sample input and integral result.
`default_nettype none

interface sie_req_if import sie_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic                       sample_last;

   modport source (output valid, output sample_value, output sample_last, input ready);
   modport sink (input valid, input sample_value, input sample_last, output ready);
endinterface

interface sie_rsp_if import sie_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] integral_value;
   logic [1:0]                 status;

   modport source (output valid, output integral_value, output status, input ready);
   modport sink (input valid, input integral_value, input status, output ready);
endinterface

`default_nettype wire

>>> sv/simpson_integral_end_corrected.sv
// Top level: Simpson integrator with end correction over a loaded sample grid.
//
//  channel  | direction | payload                              | handshake
//  req_chan | in        | sample_value[31:0], sample_last      | valid/ready
//  rsp_chan | out       | integral_value[63:0], status[1:0]    | valid/ready
//  csr_*    | in        | csr_index[2:0], csr_wdata[31:0]      | csr_we
//
// Samples load one item per cycle while the sequencer is idle. The item with
// sample_last starts the walk over N range intervals: one memory read per point
// (at most N+4), two multiplier passes and four divide-by-three digit steps,
// with req_chan.ready low throughout; a rejected burst skips the walk.
// Reset is synchronous and clears control state, not the sample memory. A
// result waits in the output register; the walk holds until that is free.
`default_nettype none

module simpson_integral_end_corrected import sie_pkg::*; #(
   parameter int SAMPLE_DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   sie_req_if.sink                   req_chan,
   sie_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [STEP_W-1:0]    csr_wdata
);

   localparam int AW    = $clog2(SAMPLE_DEPTH);
   localparam int CNT_W = $clog2(SAMPLE_DEPTH + 2);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W + 1 : CFG_W + 1;

   cfg_type          cfg_ff;
   logic [CNT_W-1:0] count_ff, count_in, count_now;

   logic                       rsp_valid_ff;
   logic signed [RESULT_W-1:0] rsp_value_ff;
   status_type                 rsp_status_ff;

   logic                       req_fire, rsp_fire, out_free;
   start_type                  start;
   logic                       walk_idle, rd_en, acc_clear, scale_go, scale_done, walk_done;
   logic [CFG_W-1:0]           rd_index;
   term_type                   term;
   status_type                 walk_status;
   logic signed [SAMPLE_W-1:0] rd_data;
   logic signed [ACC_W-1:0]    acc;
   logic signed [RESULT_W-1:0] scale_value;
   logic                       wr_en;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // load count saturates one past the depth so overflow reads as a mismatch
   assign count_now = (count_ff < CNT_W'(SAMPLE_DEPTH + 1)) ?
                      count_ff + CNT_W'(1) : count_ff;
   assign wr_en     = req_fire && (count_ff < CNT_W'(SAMPLE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         count_in = req_chan.sample_last ? '0 : count_now;
      end
   end

   assign start.go        = req_fire && req_chan.sample_last;
   assign start.bad_range = (cfg_ff.grid_first > cfg_ff.grid_last) ||
                            (cfg_ff.range_start > cfg_ff.range_end) ||
                            (cfg_ff.range_start < cfg_ff.grid_first) ||
                            (cfg_ff.range_end > cfg_ff.grid_last) ||
                            (CMP_W'(cfg_ff.grid_last) >= CMP_W'(SAMPLE_DEPTH));
   assign start.count_bad = CMP_W'(count_now) != (CMP_W'(cfg_ff.grid_last) + CMP_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size   <= 32'h0100_0000;
         cfg_ff.grid_first  <= '0;
         cfg_ff.grid_last   <= '1;
         cfg_ff.range_start <= '0;
         cfg_ff.range_end   <= '0;
         count_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_STEP_SIZE:   cfg_ff.step_size   <= csr_wdata;
               REG_GRID_FIRST:  cfg_ff.grid_first  <= csr_wdata[CFG_W-1:0];
               REG_GRID_LAST:   cfg_ff.grid_last   <= csr_wdata[CFG_W-1:0];
               REG_RANGE_START: cfg_ff.range_start <= csr_wdata[CFG_W-1:0];
               REG_RANGE_END:   cfg_ff.range_end   <= csr_wdata[CFG_W-1:0];
               default: begin
               end
            endcase
         end
         count_ff <= count_in;
         if (walk_done) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= walk_status;
            rsp_value_ff  <= (walk_status == STATUS_OK) ? scale_value : '0;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   sie_store #(
      .DEPTH (SAMPLE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_chan.sample_value),
      .rd_en   (rd_en),
      .rd_addr (AW'(rd_index)),
      .rd_data (rd_data)
   );

   sie_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cfg        (cfg_ff),
      .out_free   (out_free),
      .scale_done (scale_done),
      .idle       (walk_idle),
      .rd_en      (rd_en),
      .rd_index   (rd_index),
      .term       (term),
      .acc_clear  (acc_clear),
      .scale_go   (scale_go),
      .done       (walk_done),
      .status     (walk_status)
   );

   sie_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .clear   (acc_clear),
      .term    (term),
      .rd_data (rd_data),
      .acc     (acc)
   );

   sie_scale u_scale (
      .clock (clock),
      .reset (reset),
      .go    (scale_go),
      .acc   (acc),
      .step  (cfg_ff.step_size),
      .done  (scale_done),
      .value (scale_value)
   );

   assign req_chan.ready          = walk_idle;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.integral_value = rsp_value_ff;
   assign rsp_chan.status         = rsp_status_ff;

endmodule

`default_nettype wire

>>> sv/sie_store.sv
// Sample memory: one write port, one registered read port.
`default_nettype none

module sie_store import sie_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic signed [SAMPLE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic signed [SAMPLE_W-1:0]      rd_data
);

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/sie_mac.sv
// Shared multiply-accumulate: one weighted sample per cycle into the running sum.
`default_nettype none

module sie_mac import sie_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       clear,
   input  wire term_type                   term,
   input  wire logic signed [SAMPLE_W-1:0] rd_data,
   output logic signed [ACC_W-1:0]         acc
);

   logic                                pend_ff, pend_in;
   logic signed [WEIGHT_W-1:0]          weight_ff;
   logic signed [ACC_W-1:0]             acc_ff, acc_in;
   logic signed [SAMPLE_W+WEIGHT_W-1:0] prod;

   // weight is registered to line up with the registered read data
   assign prod    = weight_ff * rd_data;
   assign pend_in = term.valid;

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (pend_ff) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      weight_ff <= term.weight;
      acc_ff    <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

>>> sv/sie_scale.sv
// Scales the weighted sum by step/24 on one shared 32x32 multiplier: two passes
// for the step product, then four base-2^16 digit steps that divide by three.
`default_nettype none

module sie_scale import sie_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     go,
   input  wire logic signed [ACC_W-1:0]  acc,
   input  wire logic [STEP_W-1:0]        step,
   output logic                          done,
   output logic signed [RESULT_W-1:0]    value
);

   localparam int LO_W     = RESULT_W - 27;
   localparam int DIGIT_W  = 16;
   localparam int PART_W   = DIGIT_W + 2;
   localparam int RECIP_SH = 19;
   // ceil(2^19 / 3): exact quotient by three for any dividend below 2^19
   localparam logic [31:0] RECIP_3 = 32'd174763;

   typedef enum logic [2:0] {
      C_IDLE,
      C_LO,
      C_HI,
      C_DIV,
      C_SIGN
   } state_type;

   state_type                  state_ff;
   logic                       neg_ff;
   logic [ACC_W-1:0]           mag_ff;
   logic [LO_W-1:0]            lo_ff;
   logic [RESULT_W-1:0]        q_ff;
   logic [1:0]                 rem_ff;
   logic [1:0]                 cnt_ff;
   logic signed [RESULT_W-1:0] value_ff;

   logic [31:0]           mul_a, mul_b;
   logic [RESULT_W-1:0]   prod;
   logic [PART_W-1:0]     part;
   logic [DIGIT_W-1:0]    digit;
   logic [PART_W-1:0]     triple;

   // remainder from the previous digit on top of the next 16 bits of the sum
   assign part   = {rem_ff, q_ff[RESULT_W-1 -: DIGIT_W]};
   assign mul_a  = (state_ff == C_LO) ? mag_ff[31:0] :
                   (state_ff == C_HI) ? 32'(mag_ff[ACC_W-1:32]) : 32'(part);
   assign mul_b  = (state_ff == C_DIV) ? RECIP_3 : step;
   assign prod   = mul_a * mul_b;
   assign digit  = prod[RECIP_SH +: DIGIT_W];
   assign triple = {2'b00, digit} + {1'b0, digit, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         unique case (state_ff)
            C_IDLE: begin
               if (go) begin
                  neg_ff   <= acc[ACC_W-1];
                  mag_ff   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
                  state_ff <= C_LO;
               end
            end
            C_LO: begin
               lo_ff    <= prod[RESULT_W-1:27];
               state_ff <= C_HI;
            end
            C_HI: begin
               q_ff     <= {prod[RESULT_W-6:0], 5'b0} + RESULT_W'(lo_ff);
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= C_DIV;
            end
            C_DIV: begin
               rem_ff <= 2'(part - triple);
               q_ff   <= {q_ff[RESULT_W-DIGIT_W-1:0], digit};
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= C_SIGN;
               end
            end
            C_SIGN: begin
               value_ff <= neg_ff ? -signed'(q_ff) : signed'(q_ff);
               state_ff <= C_IDLE;
            end
            default: begin
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

   assign done  = (state_ff == C_SIGN);
   assign value = value_ff;

endmodule

`default_nettype wire

>>> sv/sie_walk.sv
// Sequencer: checks the burst, walks the Simpson points and the end-rule
// points through the shared MAC, then hands the sum to the scaler.
`default_nettype none

module sie_walk import sie_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire start_type   start,
   input  wire cfg_type     cfg,
   input  wire logic        out_free,
   input  wire logic        scale_done,
   output logic             idle,
   output logic             rd_en,
   output logic [CFG_W-1:0] rd_index,
   output term_type         term,
   output logic             acc_clear,
   output logic             scale_go,
   output logic             done,
   output status_type       status
);

   typedef enum logic [2:0] {
      W_IDLE,
      W_SIMP,
      W_END,
      W_DRAIN,
      W_LAUNCH,
      W_WAIT,
      W_FINISH
   } state_type;

   typedef enum logic [2:0] {
      R_NONE,
      R_TRAP,
      R_CUBIC,
      R_LEFT,
      R_RIGHT
   } rule_type;

   state_type        state_ff;
   rule_type         rule_ff;
   status_type       status_ff;
   logic [CFG_W-1:0] k_ff, ia_ff, ibb_ff;
   logic             end_ff;
   logic [1:0]       e_ff;

   logic [CFG_W-1:0] ibb_c;
   rule_type         rule_c;
   logic             end_c;
   logic signed [2:0] off_c;
   logic signed [WEIGHT_W-1:0] w_c;
   logic             last_c;

   // odd point count: keep the whole range, else leave the last interval over
   assign ibb_c = (cfg.range_end[0] ^ cfg.range_start[0]) ?
                  cfg.range_end - CFG_W'(1) : cfg.range_end;

   always_comb begin
      if (ibb_c == cfg.grid_first && cfg.range_end == cfg.grid_last) begin
         rule_c = R_TRAP;
      end else if (ibb_c > cfg.grid_first && cfg.range_end < cfg.grid_last) begin
         rule_c = R_CUBIC;
      end else if (ibb_c > cfg.grid_first) begin
         rule_c = R_LEFT;
      end else if (cfg.range_end < cfg.grid_last) begin
         rule_c = R_RIGHT;
      end else begin
         rule_c = R_NONE;
      end
   end

   assign end_c = (cfg.range_end != ibb_c) && (rule_c != R_NONE);

   // end-rule points, offsets relative to a (b = a+1)
   always_comb begin
      off_c  = 3'sd0;
      w_c    = '0;
      last_c = 1'b1;
      unique case (rule_ff)
         R_TRAP: begin
            off_c  = (e_ff == 2'd0) ? 3'sd0 : 3'sd1;
            w_c    = W_TRAP;
            last_c = (e_ff != 2'd0);
         end
         R_CUBIC: begin
            unique case (e_ff)
               2'd0: begin off_c = -3'sd1; w_c = W_CUBIC_OUT; last_c = 1'b0; end
               2'd1: begin off_c = 3'sd0;  w_c = W_CUBIC_IN;  last_c = 1'b0; end
               2'd2: begin off_c = 3'sd1;  w_c = W_CUBIC_IN;  last_c = 1'b0; end
               default: begin off_c = 3'sd2; w_c = W_CUBIC_OUT; last_c = 1'b1; end
            endcase
         end
         R_LEFT: begin
            unique case (e_ff)
               2'd0: begin off_c = -3'sd1; w_c = W_QUAD_OUT;  last_c = 1'b0; end
               2'd1: begin off_c = 3'sd0;  w_c = W_QUAD_NEAR; last_c = 1'b0; end
               default: begin off_c = 3'sd1; w_c = W_QUAD_FAR; last_c = 1'b1; end
            endcase
         end
         R_RIGHT: begin
            unique case (e_ff)
               2'd0: begin off_c = 3'sd0; w_c = W_QUAD_FAR;  last_c = 1'b0; end
               2'd1: begin off_c = 3'sd1; w_c = W_QUAD_NEAR; last_c = 1'b0; end
               default: begin off_c = 3'sd2; w_c = W_QUAD_OUT; last_c = 1'b1; end
            endcase
         end
         default: begin
            off_c  = 3'sd0;
            w_c    = '0;
            last_c = 1'b1;
         end
      endcase
   end

   always_comb begin
      rd_en       = 1'b0;
      rd_index    = k_ff;
      term.valid  = 1'b0;
      term.weight = '0;
      unique case (state_ff)
         W_SIMP: begin
            rd_en      = 1'b1;
            term.valid = 1'b1;
            if (k_ff == ia_ff || k_ff == ibb_ff) begin
               term.weight = W_SIMP_END;
            end else if (k_ff[0] ^ ia_ff[0]) begin
               term.weight = W_SIMP_ODD;
            end else begin
               term.weight = W_SIMP_EVEN;
            end
         end
         W_END: begin
            rd_en       = 1'b1;
            rd_index    = ibb_ff + CFG_W'(off_c);
            term.valid  = 1'b1;
            term.weight = w_c;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= W_IDLE;
         status_ff <= STATUS_OK;
      end else begin
         unique case (state_ff)
            W_IDLE: begin
               if (start.go) begin
                  if (start.bad_range) begin
                     status_ff <= STATUS_BAD_RANGE;
                     state_ff  <= W_FINISH;
                  end else if (start.count_bad) begin
                     status_ff <= STATUS_COUNT;
                     state_ff  <= W_FINISH;
                  end else begin
                     status_ff <= STATUS_OK;
                     k_ff      <= cfg.range_start;
                     ia_ff     <= cfg.range_start;
                     ibb_ff    <= ibb_c;
                     rule_ff   <= rule_c;
                     end_ff    <= end_c;
                     e_ff      <= '0;
                     if (ibb_c != cfg.range_start) begin
                        state_ff <= W_SIMP;
                     end else if (end_c) begin
                        state_ff <= W_END;
                     end else begin
                        state_ff <= W_DRAIN;
                     end
                  end
               end
            end
            W_SIMP: begin
               k_ff <= k_ff + CFG_W'(1);
               if (k_ff == ibb_ff) begin
                  state_ff <= end_ff ? W_END : W_DRAIN;
               end
            end
            W_END: begin
               e_ff <= e_ff + 2'd1;
               if (last_c) begin
                  state_ff <= W_DRAIN;
               end
            end
            W_DRAIN: begin
               state_ff <= W_LAUNCH;
            end
            W_LAUNCH: begin
               state_ff <= W_WAIT;
            end
            W_WAIT: begin
               if (scale_done) begin
                  state_ff <= W_FINISH;
               end
            end
            W_FINISH: begin
               if (out_free) begin
                  state_ff <= W_IDLE;
               end
            end
            default: begin
               state_ff <= W_IDLE;
            end
         endcase
      end
   end

   assign idle      = (state_ff == W_IDLE);
   assign acc_clear = idle && start.go;
   assign scale_go  = (state_ff == W_LAUNCH);
   assign done      = (state_ff == W_FINISH) && out_free;
   assign status    = status_ff;

endmodule

`default_nettype wire

>>> verif/simpson_integral_end_corrected_tb.sv
// Testbench for the Simpson integrator: random sample bursts checked against a predictor.
`timescale 1ns / 1ps

module simpson_integral_end_corrected_tb;
   import sie_pkg::*;

   localparam int SAMPLE_DEPTH  = 1024;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int SETTLE_CYCLES = 100;
   localparam int END_CYCLES    = 1200;

   typedef struct {
      logic signed [RESULT_W-1:0] value;
      status_type                 status;
   } integral_result_type;

   typedef enum {PAT_RANDOM, PAT_MAX, PAT_MIN, PAT_ALTERNATE} sample_pattern_type;

   // Predicts the integral of each burst and checks the block's results in order.
   class integral_scoreboard;
      logic [STEP_W-1:0]          step_size;
      logic [CFG_W-1:0]           grid_first, grid_last, range_start, range_end;
      logic signed [SAMPLE_W-1:0] grid_samples [SAMPLE_DEPTH];
      int unsigned                samples_loaded;
      integral_result_type        pending_integrals [$];
      int                         fail_count;

      function new();
         step_size      = 32'h0100_0000;
         grid_first     = '0;
         grid_last      = '1;
         range_start    = '0;
         range_end      = '0;
         samples_loaded = 0;
         fail_count     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [STEP_W-1:0] data);
         case (idx)
            REG_STEP_SIZE:   step_size   = data;
            REG_GRID_FIRST:  grid_first  = data[CFG_W-1:0];
            REG_GRID_LAST:   grid_last   = data[CFG_W-1:0];
            REG_RANGE_START: range_start = data[CFG_W-1:0];
            REG_RANGE_END:   range_end   = data[CFG_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_integrals.size();
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] v, logic last);
         integral_result_type r;
         longint              simpson_sum, end_term, total, fa, fb;
         int unsigned         lo, hi, simp_hi, k;
         logic [127:0]        scaled;
         logic [63:0]         mag;
         if (samples_loaded < SAMPLE_DEPTH) grid_samples[samples_loaded] = v;
         // count saturates one past the store depth so an overlong burst reads as a mismatch
         if (samples_loaded <= SAMPLE_DEPTH) samples_loaded++;
         if (!last) return;
         r.value  = '0;
         r.status = STATUS_OK;
         if (grid_first > grid_last || range_start > range_end ||
             range_start < grid_first || range_end > grid_last) begin
            r.status = STATUS_BAD_RANGE;
         end else if (samples_loaded != grid_last + 1) begin
            r.status = STATUS_COUNT;
         end else begin
            lo          = range_start;
            hi          = range_end;
            simp_hi     = hi;
            simpson_sum = 0;
            end_term    = 0;
            // Simpson covers the longest odd-count prefix
            if (((hi - lo + 1) & 1) == 0) simp_hi = hi - 1;
            if (simp_hi - lo > 1) begin
               simpson_sum = longint'(grid_samples[lo]) + longint'(grid_samples[simp_hi]);
               for (k = lo + 1; k < simp_hi; k++)
                  simpson_sum += (((k - lo) % 2 == 1) ? 4 : 2) * longint'(grid_samples[k]);
            end
            // leftover interval, weights scaled by 24
            if (hi > simp_hi) begin
               fa = grid_samples[simp_hi];
               fb = grid_samples[hi];
               if (simp_hi == grid_first && hi == grid_last)
                  end_term = 12 * (fa + fb);
               else if (simp_hi > grid_first && hi < grid_last)
                  end_term = 13 * (fa + fb) - longint'(grid_samples[simp_hi - 1])
                             - longint'(grid_samples[hi + 1]);
               else if (simp_hi > grid_first)
                  end_term = 2 * (8 * fa + 5 * fb - longint'(grid_samples[simp_hi - 1]));
               else if (hi < grid_last)
                  end_term = 2 * (5 * fa + 8 * fb - longint'(grid_samples[hi + 1]));
            end
            total = 8 * simpson_sum + end_term;
            mag   = (total < 0) ? -total : total;
            // step is Q8.24 and sums carry a factor of 24: divide by 3 * 2^27, toward zero
            scaled  = ({64'd0, mag} * {96'd0, step_size}) >> 27;
            scaled  = scaled / 3;
            r.value = (total < 0) ? -$signed(scaled[63:0]) : $signed(scaled[63:0]);
         end
         pending_integrals.push_back(r);
         samples_loaded = 0;
      endfunction

      function void check_result(logic signed [RESULT_W-1:0] v, logic [1:0] st);
         integral_result_type e;
         if (pending_integrals.size() == 0) begin
            $display("%0t: unexpected result, integral_value %0d status %0d", $time, v, st);
            fail_count++;
            return;
         end
         e = pending_integrals.pop_front();
         if (v !== e.value) begin
            $display("%0t: integral_value expected %0d, actual %0d", $time, e.value, v);
            fail_count++;
         end
         if (st !== e.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, e.status, st);
            fail_count++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [STEP_W-1:0]    csr_wdata;

   sie_req_if req_chan ();
   sie_rsp_if rsp_chan ();

   integral_scoreboard sb = new();

   bit req_steady;
   bit rsp_steady;
   int rsp_hold_request;

   simpson_integral_end_corrected #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("simpson_integral_end_corrected: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_sample(req_chan.sample_value, req_chan.sample_last);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.integral_value, rsp_chan.status);
      end
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic cfg_type make_cfg(logic [STEP_W-1:0] step, int unsigned gf, int unsigned gl,
                                        int unsigned rs, int unsigned re);
      cfg_type c;
      c.step_size   = step;
      c.grid_first  = gf[CFG_W-1:0];
      c.grid_last   = gl[CFG_W-1:0];
      c.range_start = rs[CFG_W-1:0];
      c.range_end   = re[CFG_W-1:0];
      return c;
   endfunction

   // result receiver: random stalls, plus long hold-offs on request
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!rsp_steady) stall_left = gap_len();
         end
      end
   end

   task automatic put_reg(csr_index_type idx, logic [STEP_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic apply_config(cfg_type c);
      put_reg(REG_STEP_SIZE,   c.step_size);
      put_reg(REG_GRID_FIRST,  {22'd0, c.grid_first});
      put_reg(REG_GRID_LAST,   {22'd0, c.grid_last});
      put_reg(REG_RANGE_START, {22'd0, c.range_start});
      put_reg(REG_RANGE_END,   {22'd0, c.range_end});
      csr_we <= 1'b0;
   endtask

   // entered and left at a falling edge; valid stays high after the item
   task automatic send_sample(logic signed [SAMPLE_W-1:0] v, logic last);
      int gap;
      gap = req_steady ? 0 : gap_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sample_value <= v;
      req_chan.sample_last  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_burst(int count, sample_pattern_type pat);
      logic signed [SAMPLE_W-1:0] v;
      for (int i = 0; i < count; i++) begin
         case (pat)
            PAT_MAX:       v = 32'sh7FFF_FFFF;
            PAT_MIN:       v = 32'sh8000_0000;
            PAT_ALTERNATE: v = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            default: begin
               case ($urandom_range(0, 9))
                  0:       v = 32'sh7FFF_FFFF;
                  1:       v = 32'sh8000_0000;
                  2, 3, 4: v = $urandom_range(0, 131072) - 65536;
                  default: v = $urandom;
               endcase
            end
         endcase
         send_sample(v, i == count - 1);
      end
   endtask

   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(cfg_type c, int count, sample_pattern_type pat);
      apply_config(c);
      send_burst(count, pat);
      wait_drain();
   endtask

   initial begin
      int unsigned       gf, gl, rs, re;
      logic [STEP_W-1:0] step;
      int                n_bursts, len, phase, random_items;
      bit                big;
      req_chan.valid        = 1'b0;
      req_chan.sample_value = '0;
      req_chan.sample_last  = 1'b0;
      csr_we                = 1'b0;
      csr_index             = REG_STEP_SIZE;
      csr_wdata             = '0;
      req_steady            = 1'b0;
      rsp_steady            = 1'b0;
      rsp_hold_request      = 0;
      reset                 = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // each end rule, pure Simpson, zero length, bad range, short burst, zero step
      run_phase(make_cfg(32'hFFFF_FFFF, 0, 1, 0, 1), 2, PAT_MAX);
      run_phase(make_cfg(32'h0100_0000, 0, 3, 1, 2), 4, PAT_RANDOM);
      run_phase(make_cfg(32'h0100_0000, 0, 2, 1, 2), 3, PAT_RANDOM);
      run_phase(make_cfg(32'hFFFF_FFFF, 0, 2, 0, 1), 3, PAT_MIN);
      run_phase(make_cfg(32'h0000_0001, 0, 4, 0, 4), 5, PAT_ALTERNATE);
      run_phase(make_cfg($urandom, 0, 0, 0, 0), 1, PAT_RANDOM);
      run_phase(make_cfg(32'h0100_0000, 2, 1, 0, 0), 1, PAT_RANDOM);
      run_phase(make_cfg(32'h0100_0000, 0, 2, 0, 2), 2, PAT_RANDOM);
      run_phase(make_cfg(32'h0000_0000, 0, 1, 0, 1), 2, PAT_RANDOM);

      phase        = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         req_steady = ($urandom_range(0, 6) == 0);
         rsp_steady = ($urandom_range(0, 6) == 0);
         case ($urandom_range(0, 7))
            0:       step = 32'hFFFF_FFFF;
            1:       step = 32'h0000_0001;
            2:       step = 32'h0100_0000;
            default: step = $urandom;
         endcase
         gl = ($urandom_range(0, 6) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
         gf = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gl);
         rs = ($urandom_range(0, 3) == 0) ? gf : $urandom_range(gf, gl);
         re = ($urandom_range(0, 3) == 0) ? gl : $urandom_range(rs, gl);
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: gf = $urandom_range(gl + 1, 1023);
               1: rs = $urandom_range(re + 1, 1023);
               2: begin
                  if (gf == 0) gf = 1;
                  rs = $urandom_range(0, gf - 1);
               end
               default: re = $urandom_range(gl + 1, 1023);
            endcase
         end
         n_bursts = $urandom_range(1, 4);
         big      = 1'b0;
         if (phase == 3) begin
            // results pile up behind a stalled receiver until the input backs up
            n_bursts         = 4;
            rsp_hold_request = 3000;
         end
         if (phase == 6) begin
            gf = 0; gl = 1023; rs = 0; re = 1023;
            n_bursts = 1;
            big      = 1'b1;
         end
         apply_config(make_cfg(step, gf, gl, rs, re));
         for (int b = 0; b < n_bursts; b++) begin
            len = gl + 1;
            if (!big && $urandom_range(0, 9) == 0)
               len = $urandom_range(0, 1) ? len + $urandom_range(1, 3)
                                          : ((len > 3) ? len - $urandom_range(1, 3) : 1);
            send_burst(len, PAT_RANDOM);
            random_items += len;
         end
         wait_drain();
         phase++;
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;

      repeat (END_CYCLES) @(posedge clock);
      if (sb.fail_count == 0)
         $display("simpson_integral_end_corrected: match");
      else
         $display("simpson_integral_end_corrected: mismatch");
      $finish;
   end

endmodule
